// ----- src/sevseg_pkg.sv -----
// ----------------------------------------------------------------------------
// sevseg_pkg
// Types, mode codes and the segment table shared by the formatter modules.
// ----------------------------------------------------------------------------
package sevseg_pkg;

   localparam logic [1:0] MODE_DEC_BLANK = 2'd0;
   localparam logic [1:0] MODE_DEC       = 2'd1;
   localparam logic [1:0] MODE_HEX       = 2'd2;

   localparam logic [7:0]  SEG_ZERO  = 8'h7e;
   localparam logic [7:0]  POINT_BIT = 8'h80;
   localparam logic [15:0] DEC_LIMIT = 16'd10000;
   localparam logic [2:0]  MAX_COUNT = 3'd4;

   typedef struct packed {
      logic [15:0] value;
      logic [1:0]  number_mode;
      logic [2:0]  digit_count;
      logic [2:0]  point_place;
      logic        right_half;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_0;
      logic [7:0] digit_1;
      logic [7:0] digit_2;
      logic [7:0] digit_3;
      logic [7:0] digit_4;
      logic [7:0] digit_5;
      logic [7:0] digit_6;
      logic [7:0] digit_7;
   } rsp_type;

   // one buffer update for the selected half; index 0 is the leftmost digit
   typedef struct packed {
      logic [3:0][7:0] codes;
      logic [3:0]      wr;
      logic [3:0]      pt;
      logic [3:0]      clr;
      logic            right_half;
   } upd_type;

   function automatic logic [7:0] seg_of(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'h0: s = 8'h7e;
         4'h1: s = 8'h30;
         4'h2: s = 8'h6d;
         4'h3: s = 8'h79;
         4'h4: s = 8'h33;
         4'h5: s = 8'h5b;
         4'h6: s = 8'h5f;
         4'h7: s = 8'h70;
         4'h8: s = 8'h7f;
         4'h9: s = 8'h7b;
         4'ha: s = 8'h77;
         4'hb: s = 8'h1f;
         4'hc: s = 8'h0d;
         4'hd: s = 8'h3d;
         4'he: s = 8'h4f;
         default: s = 8'h47;
      endcase
      return s;
   endfunction

endpackage

// ----- src/sevseg_digits.sv -----
// ----------------------------------------------------------------------------
// sevseg_digits
// Converts one request into four segment codes plus write, point and clear
// masks for the selected half of the display buffer.
// ----------------------------------------------------------------------------
module sevseg_digits (
   input  sevseg_pkg::req_type req,
   output sevseg_pkg::upd_type upd
);

   logic [15:0] v;
   logic        hex;
   logic        blank;
   logic        over;
   logic [31:0] p10;
   logic [33:0] p100;
   logic [32:0] p1000;
   logic [32:0] p10000;
   logic [12:0] q10;
   logic [9:0]  q100;
   logic [6:0]  q1000;
   logic [2:0]  q10000;
   logic [3:0]  d_units;
   logic [3:0]  d_tens;
   logic [3:0]  d_hund;
   logic [3:0]  d_thou;
   logic [3:0][3:0] dig;
   logic [3:0]  zero;
   logic [3:0]  blk;
   logic [2:0]  cnt;
   logic [3:0][7:0] codes;
   logic [3:0]  pt;

   // low nibble of 10*b; the digit differences below stay in 0..9
   function automatic logic [3:0] times10_lo(input logic [3:0] b);
      return 4'({b, 3'b000} + {2'b00, b, 1'b0});
   endfunction

   assign v     = req.value;
   assign hex   = req.number_mode[1];
   assign blank = (req.number_mode != sevseg_pkg::MODE_DEC);
   assign over  = !hex && (v >= sevseg_pkg::DEC_LIMIT);

   // reciprocal multiplies, exact over the 16-bit range
   assign p10    = 32'(v) * 32'd52429;
   assign p100   = 34'(v) * 34'd167773;
   assign p1000  = 33'(v) * 33'd67109;
   assign p10000 = 33'(v) * 33'd107375;
   assign q10    = p10[31:19];
   assign q100   = p100[33:24];
   assign q1000  = p1000[32:26];
   assign q10000 = p10000[32:30];

   assign d_units = v[3:0] - times10_lo(q10[3:0]);
   assign d_tens  = q10[3:0] - times10_lo(q100[3:0]);
   assign d_hund  = q100[3:0] - times10_lo(q1000[3:0]);
   assign d_thou  = q1000[3:0] - times10_lo({1'b0, q10000});

   always_comb begin
      if (hex) begin
         dig[0] = (v < 16'd256) ? 4'd0 : v[15:12];
         dig[1] = (v < 16'd256) ? 4'd0 : v[11:8];
         dig[2] = v[7:4];
         dig[3] = v[3:0];
      end else if (over) begin
         dig[0] = {1'b0, q10000};
         dig[1] = d_thou;
         dig[2] = d_hund;
         dig[3] = d_tens;
      end else begin
         dig[0] = q1000[3:0];
         dig[1] = d_hund;
         dig[2] = d_tens;
         dig[3] = d_units;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         zero[i] = (dig[i] == 4'd0);
      end
      // leading-zero blanking; third code only kept when point sits on it
      blk[0] = blank && zero[0];
      blk[1] = blk[0] && zero[1];
      blk[2] = blk[1] && zero[2] && (req.point_place != 3'd3);
      blk[3] = 1'b0;
      for (int i = 0; i < 4; i++) begin
         codes[i] = blk[i] ? 8'h00 : sevseg_pkg::seg_of(dig[i]);
      end
   end

   assign cnt = (req.digit_count > sevseg_pkg::MAX_COUNT) ? sevseg_pkg::MAX_COUNT
                                                          : req.digit_count;

   always_comb begin
      pt = 4'b0000;
      if (over) begin
         pt[1] = 1'b1;
      end else if (req.point_place >= 3'd1 && req.point_place <= 3'd4) begin
         pt[2'(req.point_place - 3'd1)] = 1'b1;
      end
   end

   always_comb begin
      upd.codes      = codes;
      upd.wr[0]      = (cnt >= 3'd4);
      upd.wr[1]      = (cnt >= 3'd3);
      upd.wr[2]      = (cnt >= 3'd2);
      upd.wr[3]      = (cnt >= 3'd1);
      upd.pt         = pt;
      upd.clr[0]     = hex && (v < 16'd4096);
      upd.clr[1]     = hex && (v < 16'd256);
      upd.clr[2]     = 1'b0;
      upd.clr[3]     = 1'b0;
      upd.right_half = req.right_half;
   end

endmodule

// ----- src/sevseg_buffer.sv -----
// ----------------------------------------------------------------------------
// sevseg_buffer
// Eight-byte display buffer. Applies one update per cycle, while upd_en is set, to one half and
// presents the whole buffer as the result payload.
// ----------------------------------------------------------------------------
module sevseg_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd_en,
   input  sevseg_pkg::upd_type upd,
   output sevseg_pkg::rsp_type rsp
);

   logic [7:0][7:0] buf_ff;
   logic [7:0][7:0] buf_in;

   always_comb begin
      logic [1:0] k;
      for (int j = 0; j < 8; j++) begin
         k = 2'(j);
         buf_in[j] = buf_ff[j];
         if (upd_en && ((j >= 4) == upd.right_half)) begin
            if (upd.wr[k]) begin
               buf_in[j] = upd.codes[k];
            end
            if (upd.pt[k]) begin
               buf_in[j] = buf_in[j] | sevseg_pkg::POINT_BIT;
            end
            if (upd.clr[k]) begin
               buf_in[j] = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
      end else begin
         buf_ff <= buf_in;
      end
   end

   assign rsp.digit_0 = buf_ff[0];
   assign rsp.digit_1 = buf_ff[1];
   assign rsp.digit_2 = buf_ff[2];
   assign rsp.digit_3 = buf_ff[3];
   assign rsp.digit_4 = buf_ff[4];
   assign rsp.digit_5 = buf_ff[5];
   assign rsp.digit_6 = buf_ff[6];
   assign rsp.digit_7 = buf_ff[7];

endmodule

// ----- src/number_to_seven_segment_formatter_top.sv -----
// ----------------------------------------------------------------------------
// number_to_seven_segment_formatter_top
// Renders a 16-bit number in decimal or hex into an eight-digit seven-segment
// buffer and returns all eight buffer bytes per request.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// rsp_valid rises after the req transfer once the request can advance: the request
// register loads at the transfer edge, then the digit conversion and buffer merge load
// the display buffer, which is the result register, when the result slot is free or taken.
// One request per cycle is sustained while rsp_ready is high.
// A stalled result holds the buffer; one more request can wait in the
// request register. Reset clears the buffer and both valid flags.
// ----------------------------------------------------------------------------
module number_to_seven_segment_formatter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sevseg_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sevseg_pkg::rsp_type rsp_data
);

   sevseg_pkg::req_type in_ff;
   logic                in_vld_ff;
   logic                in_vld_in;
   logic                rsp_vld_ff;
   logic                rsp_vld_in;
   logic                adv;
   sevseg_pkg::upd_type upd;

   assign adv       = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign rsp_valid = rsp_vld_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   sevseg_digits u_digits (
      .req (in_ff),
      .upd (upd)
   );

   sevseg_buffer u_buffer (
      .clock  (clock),
      .reset  (reset),
      .upd_en (adv),
      .upd    (upd),
      .rsp    (rsp_data)
   );

   // buffer only moves when a request transfers into it
   a_buf_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(rsp_data))
      else $error("display buffer changed without an update");

   a_rsp_after_adv: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid)
      else $error("no result after buffer update");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && rsp_vld_ff && !rsp_ready))
      else $error("request stalled while pipeline can move");

   a_hex_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && in_ff.number_mode[1] && (in_ff.value < 16'd4096) && !in_ff.right_half)
      |=> (rsp_data.digit_0 == 8'h00))
      else $error("hex leading digit not cleared");

endmodule
